// ===== design/sm3_hash_engine_top_defines.svh =====
// Assertion macros used by the SM3 hash engine checker.
`ifndef SM3_HASH_ENGINE_TOP_DEFINES_SVH
`define SM3_HASH_ENGINE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SM3_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("SM3 check failed");

// The consequent must hold in the cycle after the antecedent.
`define SM3_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("SM3 check failed");

`endif

// ===== design/sm3_pkg.sv =====
`default_nettype none
package sm3_pkg;

   typedef logic [31:0] word_type;

   localparam word_type SM3_IV [8] = '{
      32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
      32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
   };
   localparam word_type TJ_LOW  = 32'h79CC4519;
   localparam word_type TJ_HIGH = 32'h7A879D8A;
   localparam word_type PAD_WORD = 32'h80000000;
   localparam logic [7:0] PAD_BYTE = 8'h80;

   // Source of the word written into the block buffer.
   typedef enum logic [1:0] {
      SRC_REQ  = 2'd0,
      SRC_PAD  = 2'd1,
      SRC_FILL = 2'd2
   } wr_src_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       wr_en;
      wr_src_type wr_src;
      logic [3:0] wr_idx;
      logic       len_ok;
      logic       add_len;
      logic       init;
      logic       start;
      logic       round;
      logic [5:0] rnd;
      logic       fold;
      logic [2:0] out_idx;
   } cmd_type;

   function automatic word_type rotl(input word_type x, input logic [4:0] n);
      return (x << n) | (x >> (6'd32 - {1'b0, n}));
   endfunction

   function automatic word_type perm0(input word_type x);
      return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
   endfunction

   function automatic word_type perm1(input word_type x);
      return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
   endfunction

endpackage
`default_nettype wire

// ===== design/sm3_req_if.sv =====
`default_nettype none
interface sm3_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] msg_word;
   logic [2:0]  word_bytes;
   logic        last_word;

   modport source (output valid, msg_word, word_bytes, last_word, input ready);
   modport sink (input valid, msg_word, word_bytes, last_word, output ready);
endinterface
`default_nettype wire

// ===== design/sm3_rsp_if.sv =====
`default_nettype none
interface sm3_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  digest_index;
   logic        digest_last;

   modport source (output valid, digest_word, digest_index, digest_last, input ready);
   modport sink (input valid, digest_word, digest_index, digest_last, output ready);
endinterface
`default_nettype wire

// ===== design/sm3_dp.sv =====
`default_nettype none
module sm3_dp (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire sm3_pkg::cmd_type cmd,
   input  wire logic [31:0]     msg_word,
   input  wire logic [2:0]      word_bytes,
   input  wire logic            last_word,
   output logic [31:0]          digest_word
);
   import sm3_pkg::*;

   word_type   buf_ff [16];
   word_type   buf_in [16];
   word_type   chain_ff [8];
   word_type   chain_in [8];
   word_type   a_ff, b_ff, c_ff, d_ff, e_ff, f_ff, g_ff, h_ff;
   word_type   a_in, b_in, c_in, d_in, e_in, f_in, g_in, h_in;
   logic [63:0] len_ff, len_in;

   logic [2:0] nbytes;
   word_type   req_word;
   word_type   wr_data;
   word_type   w_new, tj, a12, ss1, ss2, ff, gg, tt1, tt2;

   // Effective byte count: partial only on the final word.
   always_comb begin
      nbytes = (!last_word || word_bytes > 3'd4) ? 3'd4 : word_bytes;
      unique case (nbytes)
         3'd0:    req_word = PAD_WORD;
         3'd1:    req_word = {msg_word[31:24], PAD_BYTE, 16'h0};
         3'd2:    req_word = {msg_word[31:16], PAD_BYTE, 8'h0};
         3'd3:    req_word = {msg_word[31:8], PAD_BYTE};
         default: req_word = msg_word;
      endcase
   end

   // Word written into the block buffer.
   always_comb begin
      unique case (cmd.wr_src)
         SRC_REQ: wr_data = req_word;
         SRC_PAD: wr_data = PAD_WORD;
         default: begin
            if (cmd.len_ok && cmd.wr_idx == 4'd14) begin
               wr_data = len_ff[63:32];
            end else if (cmd.len_ok && cmd.wr_idx == 4'd15) begin
               wr_data = len_ff[31:0];
            end else begin
               wr_data = '0;
            end
         end
      endcase
   end

   // One compression round with the message schedule held as a sliding window.
   always_comb begin
      w_new = perm1(buf_ff[0] ^ buf_ff[7] ^ rotl(buf_ff[13], 5'd15))
              ^ rotl(buf_ff[3], 5'd7) ^ buf_ff[10];
      tj  = (cmd.rnd < 6'd16) ? TJ_LOW : TJ_HIGH;
      a12 = rotl(a_ff, 5'd12);
      ss1 = rotl(a12 + e_ff + rotl(tj, cmd.rnd[4:0]), 5'd7);
      ss2 = ss1 ^ a12;
      if (cmd.rnd < 6'd16) begin
         ff = a_ff ^ b_ff ^ c_ff;
         gg = e_ff ^ f_ff ^ g_ff;
      end else begin
         ff = (a_ff & b_ff) | (a_ff & c_ff) | (b_ff & c_ff);
         gg = (e_ff & f_ff) | (~e_ff & g_ff);
      end
      tt1 = ff + d_ff + ss2 + (buf_ff[0] ^ buf_ff[4]);
      tt2 = gg + h_ff + ss1 + buf_ff[0];
   end

   // Next state of the buffer, working variables, chain and length.
   always_comb begin
      buf_in   = buf_ff;
      chain_in = chain_ff;
      len_in   = len_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff;
      e_in = e_ff; f_in = f_ff; g_in = g_ff; h_in = h_ff;
      if (cmd.wr_en) begin
         buf_in[cmd.wr_idx] = wr_data;
      end
      if (cmd.add_len) begin
         len_in = len_ff + {58'h0, nbytes, 3'b000};
      end
      if (cmd.start) begin
         a_in = chain_ff[0]; b_in = chain_ff[1]; c_in = chain_ff[2]; d_in = chain_ff[3];
         e_in = chain_ff[4]; f_in = chain_ff[5]; g_in = chain_ff[6]; h_in = chain_ff[7];
      end
      if (cmd.round) begin
         for (int i = 0; i < 15; i++) begin
            buf_in[i] = buf_ff[i + 1];
         end
         buf_in[15] = w_new;
         d_in = c_ff; c_in = rotl(b_ff, 5'd9); b_in = a_ff; a_in = tt1;
         h_in = g_ff; g_in = rotl(f_ff, 5'd19); f_in = e_ff; e_in = perm0(tt2);
      end
      if (cmd.fold) begin
         chain_in[0] = chain_ff[0] ^ a_ff; chain_in[1] = chain_ff[1] ^ b_ff;
         chain_in[2] = chain_ff[2] ^ c_ff; chain_in[3] = chain_ff[3] ^ d_ff;
         chain_in[4] = chain_ff[4] ^ e_ff; chain_in[5] = chain_ff[5] ^ f_ff;
         chain_in[6] = chain_ff[6] ^ g_ff; chain_in[7] = chain_ff[7] ^ h_ff;
      end
      if (cmd.init) begin
         chain_in = SM3_IV;
         len_in   = '0;
      end
   end

   // Chain and length reset; buffer and working variables need none.
   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= SM3_IV;
         len_ff   <= '0;
      end else begin
         chain_ff <= chain_in;
         len_ff   <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in;
      e_ff <= e_in; f_ff <= f_in; g_ff <= g_in; h_ff <= h_in;
   end

   assign digest_word = chain_ff[cmd.out_idx];

endmodule
`default_nettype wire

// ===== design/sm3_ctrl.sv =====
`default_nettype none
module sm3_ctrl (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic [2:0]  req_bytes,
   input  wire logic        req_last,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_index,
   output logic             rsp_last,
   output sm3_pkg::cmd_type cmd
);
   import sm3_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_PAD  = 5'b00010,
      S_COMP = 5'b00100,
      S_FOLD = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [5:0] rnd_ff, rnd_in;
   logic [2:0] oidx_ff, oidx_in;
   logic       final_ff, final_in;
   logic       pend_ff, pend_in;
   logic       lenok_ff, lenok_in;
   logic       done_ff, done_in;
   logic       full_word;

   assign full_word = !req_last || req_bytes >= 3'd4;
   assign rsp_index = oidx_ff;
   assign rsp_last  = (oidx_ff == 3'd7);

   // Sequencer for fill, padding, compression and digest readout.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rnd_in   = rnd_ff;
      oidx_in  = oidx_ff;
      final_in = final_ff;
      pend_in  = pend_ff;
      lenok_in = lenok_ff;
      done_in  = done_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd = '0;
      cmd.wr_src  = SRC_REQ;
      cmd.wr_idx  = cnt_ff;
      cmd.len_ok  = lenok_ff;
      cmd.rnd     = rnd_ff;
      cmd.out_idx = oidx_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.wr_en   = 1'b1;
               cmd.add_len = 1'b1;
               cnt_in = cnt_ff + 4'd1;
               if (req_last) begin
                  final_in = 1'b1;
                  pend_in  = full_word;
                  lenok_in = !full_word && cnt_ff <= 4'd13;
               end
               if (cnt_ff == 4'd15) begin
                  cmd.start = 1'b1;
                  rnd_in = '0;
                  state_in = S_COMP;
               end else if (req_last) begin
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = pend_ff ? SRC_PAD : SRC_FILL;
            cnt_in = cnt_ff + 4'd1;
            if (pend_ff) begin
               pend_in  = 1'b0;
               lenok_in = cnt_ff <= 4'd13;
            end
            if (cnt_ff == 4'd15) begin
               cmd.start = 1'b1;
               rnd_in  = '0;
               done_in = !pend_ff && lenok_ff;
               state_in = S_COMP;
            end
         end
         S_COMP: begin
            cmd.round = 1'b1;
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            cmd.fold = 1'b1;
            if (done_ff) begin
               state_in = S_OUT;
            end else if (final_ff) begin
               lenok_in = 1'b1;
               state_in = S_PAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  cmd.init = 1'b1;
                  final_in = 1'b0;
                  done_in  = 1'b0;
                  cnt_in   = '0;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         rnd_ff   <= '0;
         oidx_ff  <= '0;
         final_ff <= 1'b0;
         pend_ff  <= 1'b0;
         lenok_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rnd_ff   <= rnd_in;
         oidx_ff  <= oidx_in;
         final_ff <= final_in;
         pend_ff  <= pend_in;
         lenok_ff <= lenok_in;
         done_ff  <= done_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/sm3_hash_engine_top.sv =====
// SM3 hash engine, one message at a time.
// The request channel carries big-endian message words; word_bytes gives the
// valid bytes and only the word flagged last_word may be partial (zero bytes
// for an empty tail). No response follows an ordinary word. After the final
// word the engine pads the message, appends the bit length and then presents
// the eight digest words on the response channel, index 0 first, with
// digest_last on the eighth.
// Timing: a request is accepted in the cycle it is offered while the engine is idle;
// every sixteenth word starts a block compression (64 rounds, one per cycle in the
// shared round unit, plus the chaining fold). The final word is followed by padding
// words, one per cycle up to the end of the block, one or two compressions, then the
// digest words, one per cycle while the receiver is ready. Requests are not taken
// while a block compresses or the digest is out.
// If the receiver holds off ready, the current digest word and index stay
// unchanged until taken. Reset loads the initial value, clears the length
// and word count and leaves the engine ready for a new message.
`default_nettype none
module sm3_hash_engine_top (
   input wire logic clock,
   input wire logic reset,
   sm3_req_if.sink  req_if,
   sm3_rsp_if.source rsp_if
);
   import sm3_pkg::*;

   cmd_type cmd;

   sm3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_bytes (req_if.word_bytes),
      .req_last  (req_if.last_word),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .rsp_index (rsp_if.digest_index),
      .rsp_last  (rsp_if.digest_last),
      .cmd       (cmd)
   );

   sm3_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .msg_word    (req_if.msg_word),
      .word_bytes  (req_if.word_bytes),
      .last_word   (req_if.last_word),
      .digest_word (rsp_if.digest_word)
   );

endmodule
`default_nettype wire

// ===== design/sm3_chk.sv =====
`default_nettype none
`include "sm3_hash_engine_top_defines.svh"
module sm3_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_word,
   input wire logic [2:0]  rsp_index,
   input wire logic        rsp_last
);
   // A stalled digest word holds.
   `SM3_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))
   // The last flag marks exactly the eighth word.
   `SM3_ASSERT_NOW(a_last_idx, rsp_valid, rsp_last == (rsp_index == 3'd7))
   // No request is taken while the digest is being read out.
   `SM3_ASSERT_NOW(a_no_overlap, rsp_valid, !req_ready)
   // Digest words follow each other in order without a gap.
   `SM3_ASSERT_NEXT(a_idx_step, rsp_valid && rsp_ready && !rsp_last,
      rsp_valid && rsp_index == $past(rsp_index) + 3'd1)
endmodule

bind sm3_hash_engine_top sm3_chk u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_word  (rsp_if.digest_word),
   .rsp_index (rsp_if.digest_index),
   .rsp_last  (rsp_if.digest_last)
);
`default_nettype wire

// ===== dv/tb_sm3_hash_engine_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_sm3_hash_engine_top;
   import sm3_pkg::*;

   // One message word as offered on the request channel.
   typedef struct packed {
      logic [31:0] msg_word;
      logic [2:0]  word_bytes;
      logic        last_word;
   } msg_item_type;

   // One digest word as expected on the response channel.
   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  digest_index;
      logic        digest_last;
   } digest_item_type;

   logic clock;
   logic reset;

   sm3_req_if req_bus ();
   sm3_rsp_if rsp_bus ();

   sm3_hash_engine_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus.sink),
      .rsp_if (rsp_bus.source)
   );

   // Hash state of the predictor.
   word_type    hash_chain [8];
   word_type    hash_block [16];
   int unsigned hash_fill;
   logic [63:0] hash_bits;

   msg_item_type    pending_words [$];
   digest_item_type expected_digests [$];

   int  mismatch_count;
   bit  stim_done;
   bit  quiet_phase;
   int  stall_left;
   int  gap_left;
   int  hold_off_left;
   bit  hold_off_armed;

   function automatic word_type rol32(word_type x, int n);
      n = n % 32;
      if (n == 0) return x;
      return (x << n) | (x >> (32 - n));
   endfunction

   // Expand the buffered block and fold 64 rounds into the chain.
   task automatic compress_block();
      word_type w [68];
      word_type wp [64];
      word_type a, b, c, d, e, f, g, h, tj, a12, ss1, ss2, ff, gg, tt1, tt2, t;
      for (int j = 0; j < 16; j++) w[j] = hash_block[j];
      for (int j = 16; j < 68; j++) begin
         t = w[j-16] ^ w[j-9] ^ rol32(w[j-3], 15);
         w[j] = (t ^ rol32(t, 15) ^ rol32(t, 23)) ^ rol32(w[j-13], 7) ^ w[j-6];
      end
      for (int j = 0; j < 64; j++) wp[j] = w[j] ^ w[j+4];
      a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2]; d = hash_chain[3];
      e = hash_chain[4]; f = hash_chain[5]; g = hash_chain[6]; h = hash_chain[7];
      for (int j = 0; j < 64; j++) begin
         tj = (j < 16) ? TJ_LOW : TJ_HIGH;
         a12 = rol32(a, 12);
         ss1 = rol32(a12 + e + rol32(tj, j % 32), 7);
         ss2 = ss1 ^ a12;
         if (j < 16) begin
            ff = a ^ b ^ c;
            gg = e ^ f ^ g;
         end else begin
            ff = (a & b) | (a & c) | (b & c);
            gg = (e & f) | (~e & g);
         end
         tt1 = ff + d + ss2 + wp[j];
         tt2 = gg + h + ss1 + w[j];
         d = c; c = rol32(b, 9); b = a; a = tt1;
         h = g; g = rol32(f, 19); f = e; e = tt2 ^ rol32(tt2, 9) ^ rol32(tt2, 17);
      end
      hash_chain[0] ^= a; hash_chain[1] ^= b; hash_chain[2] ^= c; hash_chain[3] ^= d;
      hash_chain[4] ^= e; hash_chain[5] ^= f; hash_chain[6] ^= g; hash_chain[7] ^= h;
   endtask

   task automatic hash_restart();
      for (int k = 0; k < 8; k++) hash_chain[k] = SM3_IV[k];
      for (int k = 0; k < 16; k++) hash_block[k] = '0;
      hash_fill = 0;
      hash_bits = '0;
   endtask

   // Absorb one accepted word; a final word pads and queues the digest.
   task automatic hash_absorb(msg_item_type it);
      int unsigned nb;
      word_type    wd, keep;
      digest_item_type dg;
      nb = it.word_bytes;
      wd = it.msg_word;
      if (nb > 4 || !it.last_word) nb = 4;
      if (!it.last_word) begin
         hash_block[hash_fill] = wd;
         hash_bits += 64'd32;
         hash_fill++;
         if (hash_fill == 16) begin
            compress_block();
            hash_fill = 0;
         end
         return;
      end
      hash_bits += 64'(nb * 8);
      if (nb < 4) begin
         keep = (nb == 0) ? '0 : (32'hFFFFFFFF << (32 - 8 * nb));
         hash_block[hash_fill] = (wd & keep) | (word_type'(PAD_BYTE) << (24 - 8 * nb));
         hash_fill++;
      end else begin
         hash_block[hash_fill] = wd;
         hash_fill++;
         if (hash_fill == 16) begin
            compress_block();
            hash_fill = 0;
         end
         hash_block[hash_fill] = PAD_WORD;
         hash_fill++;
      end
      if (hash_fill > 14) begin
         while (hash_fill < 16) hash_block[hash_fill++] = '0;
         compress_block();
         hash_fill = 0;
      end
      while (hash_fill < 14) hash_block[hash_fill++] = '0;
      hash_block[14] = hash_bits[63:32];
      hash_block[15] = hash_bits[31:0];
      compress_block();
      for (int k = 0; k < 8; k++) begin
         dg.digest_word = hash_chain[k];
         dg.digest_index = 3'(k);
         dg.digest_last = (k == 7);
         expected_digests.push_back(dg);
      end
      hash_restart();
   endtask

   // Queue one message of the given length in words, ending with a tail.
   task automatic add_message(int n_words, logic [2:0] tail_bytes);
      msg_item_type it;
      for (int k = 0; k < n_words; k++) begin
         it.msg_word = $urandom();
         it.word_bytes = 3'($urandom_range(0, 7));
         it.last_word = 1'b0;
         pending_words.push_back(it);
      end
      it.msg_word = $urandom();
      it.word_bytes = tail_bytes;
      it.last_word = 1'b1;
      pending_words.push_back(it);
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Request driver with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left <= 0;
      end else if (req_bus.valid && !req_bus.ready) begin
         // Hold the current request.
      end else if (gap_left > 0) begin
         req_bus.valid <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_words.size() > 0) begin
         req_bus.valid <= 1'b1;
         {req_bus.msg_word, req_bus.word_bytes, req_bus.last_word} <= pending_words.pop_front();
         if (!quiet_phase && $urandom_range(0, 9) == 0) gap_left <= $urandom_range(1, 11);
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // Absorb every accepted request into the predictor.
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         hash_absorb({req_bus.msg_word, req_bus.word_bytes, req_bus.last_word});
   end

   // Response ready with random stalls and one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= 0;
         hold_off_left <= 0;
      end else if (hold_off_armed && hold_off_left == 0 && expected_digests.size() > 0) begin
         hold_off_armed <= 1'b0;
         hold_off_left <= 400;
         rsp_bus.ready <= 1'b0;
      end else if (hold_off_left > 0) begin
         hold_off_left <= hold_off_left - 1;
         rsp_bus.ready <= (hold_off_left == 1);
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_bus.ready <= (stall_left == 1);
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 11);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Compare each digest word with the oldest expectation.
   always @(posedge clock) begin
      digest_item_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_digests.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected digest word %h index %0d", rsp_bus.digest_word,
                        rsp_bus.digest_index);
         end else begin
            want = expected_digests.pop_front();
            if (rsp_bus.digest_word !== want.digest_word
                || rsp_bus.digest_index !== want.digest_index
                || rsp_bus.digest_last !== want.digest_last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                           want.digest_word, want.digest_index, want.digest_last,
                           rsp_bus.digest_word, rsp_bus.digest_index, rsp_bus.digest_last);
            end
         end
      end
   end

   // Stimulus: directed messages, then random ones; the last part runs without idling.
   initial begin
      msg_item_type it;
      int total;
      mismatch_count = 0;
      stim_done = 1'b0;
      quiet_phase = 1'b0;
      hold_off_armed = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.msg_word = '0;
      req_bus.word_bytes = '0;
      req_bus.last_word = 1'b0;
      rsp_bus.ready = 1'b0;
      hash_restart();
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Empty message, the classic "abc", all tail sizes and the pad boundaries.
      add_message(0, 3'd0);
      it.msg_word = 32'h61626300; it.word_bytes = 3'd3; it.last_word = 1'b1;
      pending_words.push_back(it);
      add_message(0, 3'd7);
      add_message(1, 3'd5);
      add_message(0, 3'd1);
      add_message(1, 3'd2);
      it.msg_word = 32'hFFFFFFFF; it.word_bytes = 3'd4; it.last_word = 1'b0;
      pending_words.push_back(it);
      it.msg_word = 32'h00000000; it.word_bytes = 3'd6; it.last_word = 1'b1;
      pending_words.push_back(it);
      add_message(13, 3'd4);
      add_message(14, 3'd3);
      total = pending_words.size();

      // Random messages, mostly short, a few spanning block edges.
      while (total < 480) begin
         int n;
         case ($urandom_range(0, 3))
            0: n = $urandom_range(0, 3);
            1: n = $urandom_range(12, 17);
            2: n = $urandom_range(28, 33);
            default: n = $urandom_range(0, 15);
         endcase
         add_message(n, 3'($urandom_range(0, 7)));
         total += n + 1;
         if (total > 150 && total < 200) hold_off_armed = 1'b1;
         while (pending_words.size() > 40) @(posedge clock);
         if (total > 400) quiet_phase = 1'b1;
      end
      while (pending_words.size() > 0 || req_bus.valid) @(posedge clock);
      while (expected_digests.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && expected_digests.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

endmodule
`default_nettype wire
